FILE: hw/rtl/bdcc_pkg.sv
// ----------------------------------------------------------------------------
// bdcc_pkg: shared types and constants for the block difference checker
// Holds sizes, input kind codes and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package bdcc_pkg;

  localparam int BLOCK_BYTES = 16384;
  localparam int DIRTY_DEPTH = 4096;
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int DADDR_W     = $clog2(DIRTY_DEPTH);
  localparam int DCNT_W      = $clog2(DIRTY_DEPTH + 1);
  localparam int POS_W       = 48;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;
  localparam logic [1:0] KIND_PAIR  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear;        // clear all state
    logic load;         // append dirty entry
    logic range_begin;  // begin range, reset pointer to zero
    logic pair;         // absorb byte pair
    logic close;        // block closes with this pair
    logic scan_rd;      // issue list read at pointer
    logic scan_step;    // examine read data, advance or finish
    logic range_scan;   // scan belongs to a begin range
  } bdcc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic blk_end;      // presented pair ends its block
    logic need_scan;    // closing block needs a list walk
    logic scan_done;    // walk finished this cycle
  } bdcc_sts_t;

endpackage

FILE: hw/rtl/bdcc_datapath.sv
// ----------------------------------------------------------------------------
// bdcc_datapath: counters, dirty list memory and earliest-difference record
// Executes commands from the controller one step per cycle.
// ----------------------------------------------------------------------------
module bdcc_datapath
  import bdcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  bdcc_cmd_t        cmd,
  output bdcc_sts_t        sts,
  input  logic             coverage_enabled,
  input  logic [1:0]       kind,
  input  logic [POS_W-1:0] position_value,
  input  logic [7:0]       baseline_byte,
  input  logic [7:0]       payload_byte,
  input  logic             end_of_range,
  output logic [POS_W-1:0] cmp_count,
  output logic [POS_W-1:0] diff_byte_count,
  output logic [POS_W-1:0] diff_block_count,
  output logic [POS_W-1:0] unc_byte_count,
  output logic [POS_W-1:0] unc_block_count,
  output logic             first_valid,
  output logic [POS_W-1:0] first_block_offset,
  output logic [POS_W-1:0] first_byte_offset,
  output logic [7:0]       first_baseline_byte,
  output logic [7:0]       first_payload_byte
);

  logic [POS_W-1:0] dirty_mem [DIRTY_DEPTH];
  logic [POS_W-1:0] rd_data;
  logic [DCNT_W-1:0] dirty_count;
  logic [DCNT_W-1:0] dirty_pointer;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] blk_start;
  logic [FILL_W-1:0] blk_fill;
  logic [FILL_W-1:0] blk_mis;
  logic [POS_W-1:0] blk_first_off;
  logic [7:0]       blk_first_a;
  logic [7:0]       blk_first_b;
  // Pending close: block values held while the list walk runs
  logic [POS_W-1:0] pend_start;
  logic [FILL_W-1:0] pend_mis;
  logic [POS_W-1:0] pend_off;
  logic [7:0]       pend_a;
  logic [7:0]       pend_b;
  logic [POS_W-1:0] target;
  logic [FILL_W-1:0] fill_inc;
  logic             diff;
  logic [FILL_W-1:0] mis_inc;
  logic             ptr_ok;
  logic             blk_end;

  assign diff     = baseline_byte != payload_byte;
  assign fill_inc = blk_fill + 1'b1;
  assign mis_inc  = blk_mis + FILL_W'(diff);
  assign ptr_ok   = dirty_pointer < dirty_count;
  assign target   = cmd.range_scan ? byte_position : pend_start;
  assign blk_end  = (fill_inc == FILL_W'(BLOCK_BYTES)) || end_of_range;

  assign sts.blk_end   = blk_end;
  assign sts.need_scan = (mis_inc != '0) && coverage_enabled && blk_end;
  assign sts.scan_done = cmd.scan_step &&
                         (!ptr_ok || !(rd_data < target));

  // Dirty list memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load && dirty_count < DCNT_W'(DIRTY_DEPTH)) begin
      dirty_mem[dirty_count[DADDR_W-1:0]] <= position_value;
    end
    if (cmd.scan_rd) begin
      rd_data <= dirty_mem[dirty_pointer[DADDR_W-1:0]];
    end
  end

  // Update counters, block tracking and the earliest record
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dirty_count      <= '0;
      dirty_pointer    <= '0;
      byte_position    <= '0;
      blk_start        <= '0;
      blk_fill         <= '0;
      blk_mis          <= '0;
      cmp_count        <= '0;
      diff_byte_count  <= '0;
      diff_block_count <= '0;
      unc_byte_count   <= '0;
      unc_block_count  <= '0;
      first_valid      <= 1'b0;
      first_block_offset  <= '0;
      first_byte_offset   <= '0;
      first_baseline_byte <= '0;
      first_payload_byte  <= '0;
    end else begin
      if (cmd.load && dirty_count < DCNT_W'(DIRTY_DEPTH)) begin
        dirty_count <= dirty_count + 1'b1;
      end
      if (cmd.range_begin) begin
        dirty_pointer <= '0;
        byte_position <= position_value;
        blk_start     <= position_value;
        blk_fill      <= '0;
        blk_mis       <= '0;
      end
      if (cmd.pair) begin
        cmp_count      <= cmp_count + 1'b1;
        byte_position  <= byte_position + 1'b1;
        if (diff && blk_mis == '0) begin
          blk_first_off <= byte_position;
          blk_first_a   <= baseline_byte;
          blk_first_b   <= payload_byte;
        end
        if (cmd.close) begin
          blk_fill  <= '0;
          blk_mis   <= '0;
          blk_start <= byte_position + 1'b1;
          if (mis_inc != '0) begin
            diff_byte_count  <= diff_byte_count + POS_W'(mis_inc);
            diff_block_count <= diff_block_count + 1'b1;
          end
          pend_start <= blk_start;
          pend_mis   <= mis_inc;
          pend_off   <= (diff && blk_mis == '0) ? byte_position : blk_first_off;
          pend_a     <= (diff && blk_mis == '0) ? baseline_byte : blk_first_a;
          pend_b     <= (diff && blk_mis == '0) ? payload_byte : blk_first_b;
        end else begin
          blk_fill <= fill_inc;
          blk_mis  <= mis_inc;
        end
      end
      // Walk step: skip smaller entries, consume an equal one on a block close walk
      if (cmd.scan_step) begin
        if (ptr_ok && rd_data < target) begin
          dirty_pointer <= dirty_pointer + 1'b1;
        end else if (!cmd.range_scan) begin
          if (ptr_ok && rd_data == target) begin
            dirty_pointer <= dirty_pointer + 1'b1;
          end else begin
            unc_byte_count  <= unc_byte_count + POS_W'(pend_mis);
            unc_block_count <= unc_block_count + 1'b1;
            if (!first_valid || pend_off < first_byte_offset) begin
              first_valid         <= 1'b1;
              first_block_offset  <= pend_start;
              first_byte_offset   <= pend_off;
              first_baseline_byte <= pend_a;
              first_payload_byte  <= pend_b;
            end
          end
        end
      end
    end
  end

  property p_load_kind;
    @(posedge clk) disable iff (rst) cmd.load |-> (kind == KIND_LOAD);
  endproperty
  a_load_kind: assert property (p_load_kind) else $error("load command without load kind");

  property p_count_bound;
    @(posedge clk) disable iff (rst) dirty_count <= DCNT_W'(DIRTY_DEPTH);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("dirty count overflow");

  property p_ptr_bound;
    @(posedge clk) disable iff (rst) dirty_pointer <= dirty_count;
  endproperty
  a_ptr_bound: assert property (p_ptr_bound) else $error("pointer past count");

  property p_fill_bound;
    @(posedge clk) disable iff (rst) blk_fill < FILL_W'(BLOCK_BYTES);
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("block fill overflow");

endmodule

FILE: hw/rtl/bdcc_ctrl.sv
// ----------------------------------------------------------------------------
// bdcc_ctrl: sequencer for word acceptance, list walks and result handoff
// Issues one command set per cycle to the datapath.
// ----------------------------------------------------------------------------
module bdcc_ctrl
  import bdcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  output logic       out_valid,
  input  logic       out_ready,
  input  bdcc_sts_t  sts,
  output bdcc_cmd_t  cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_STEP} state_t;

  state_t state;
  logic   range_scan;
  logic   accept;
  logic   pend_out;
  logic   start_walk;
  logic   out_set;

  assign pend_out   = out_valid && !out_ready;
  assign in_ready   = (state == ST_IDLE) && !pend_out;
  assign accept     = in_valid && in_ready;
  assign start_walk = accept &&
                      ((kind == KIND_RANGE) || (kind == KIND_PAIR && sts.need_scan));
  assign out_set    = (accept && !start_walk) ||
                      ((state == ST_STEP) && sts.scan_done);

  // Decode commands for the current state
  always_comb begin
    cmd = '0;
    cmd.range_scan = range_scan;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.clear       = kind == KIND_CLEAR;
          cmd.load        = kind == KIND_LOAD;
          cmd.range_begin = kind == KIND_RANGE;
          cmd.pair        = kind == KIND_PAIR;
          cmd.close       = (kind == KIND_PAIR) && sts.blk_end;
        end
      end
      ST_READ: cmd.scan_rd = 1'b1;
      ST_STEP: cmd.scan_step = 1'b1;
      default: cmd = '0;
    endcase
  end

  // Hold state and the registered result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      range_scan <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start_walk) begin
            range_scan <= kind == KIND_RANGE;
            state      <= ST_READ;
          end
        end
        ST_READ: state <= ST_STEP;
        ST_STEP: begin
          if (sts.scan_done) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !in_ready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_read_then_step;
    @(posedge clk) disable iff (rst) (state == ST_READ) |=> (state == ST_STEP);
  endproperty
  a_read_then_step: assert property (p_read_then_step) else $error("walk order broken");

  property p_done_gives_result;
    @(posedge clk) disable iff (rst) sts.scan_done |=> out_valid;
  endproperty
  a_done_gives_result: assert property (p_done_gives_result) else $error("lost result");

endmodule

FILE: hw/rtl/block_diff_coverage_checker_core.sv
// ----------------------------------------------------------------------------
// block_diff_coverage_checker_core: byte stream diff with dirty-list coverage
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | kind, position_value, bytes, end_of_range
//   out     | output    | out_valid / out_ready  | totals and earliest uncovered record
//   cfg     | input     | cfg_we                 | cfg_wdata -> coverage_enabled
//
// A load, a clear or a pair with no list walk is done in the idle state.
// A begin range, or a closing differing block with coverage on, walks the
// dirty list, reading each entry (registered read) before it is examined.
// A block closes at end of range or after BLOCK_BYTES pairs.
// A word is taken while no walk runs and no result waits; a stalled result holds the input.
// Reset is synchronous; the dirty list holds no reset, a fill count guards it.
// ----------------------------------------------------------------------------
module block_diff_coverage_checker_core
  import bdcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       kind,
  input  logic [POS_W-1:0] position_value,
  input  logic [7:0]       baseline_byte,
  input  logic [7:0]       payload_byte,
  input  logic             end_of_range,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [POS_W-1:0] cmp_count,
  output logic [POS_W-1:0] diff_byte_count,
  output logic [POS_W-1:0] diff_block_count,
  output logic [POS_W-1:0] unc_byte_count,
  output logic [POS_W-1:0] unc_block_count,
  output logic             first_valid,
  output logic [POS_W-1:0] first_block_offset,
  output logic [POS_W-1:0] first_byte_offset,
  output logic [7:0]       first_baseline_byte,
  output logic [7:0]       first_payload_byte
);

  logic      coverage_enabled;
  bdcc_cmd_t cmd;
  bdcc_sts_t sts;

  // Hold the coverage enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      coverage_enabled <= 1'b0;
    end else if (cfg_we) begin
      coverage_enabled <= cfg_wdata;
    end
  end

  bdcc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind,
    .out_valid, .out_ready, .sts, .cmd
  );

  bdcc_datapath u_dp (
    .clk, .rst, .cmd, .sts, .coverage_enabled, .kind, .position_value,
    .baseline_byte, .payload_byte, .end_of_range,
    .cmp_count, .diff_byte_count, .diff_block_count,
    .unc_byte_count, .unc_block_count, .first_valid,
    .first_block_offset, .first_byte_offset,
    .first_baseline_byte, .first_payload_byte
  );

endmodule
